### sv/sctb_pkg.sv
`default_nettype none

package sctb_pkg;

	localparam int MAX_SRC_W   = 256;
	localparam int MAX_SRC_H   = 256;
	localparam int FRAME_DEPTH = MAX_SRC_W * MAX_SRC_H;
	localparam int ADDR_W      = $clog2(FRAME_DEPTH);

	localparam int SRC_ADDR_W = 16;
	localparam int PIX_W      = 32;
	localparam int CHAN_W     = 8;
	localparam int RGB_W      = 3 * CHAN_W;
	localparam int COORD_W    = 8;
	localparam int DIM_W      = 9;
	localparam int POS_W      = 13;

	// mapping numerator, its magnitude and the quotient width
	localparam int T_W    = POS_W + DIM_W + 1;
	localparam int MAG_W  = T_W - 1;
	localparam int FRAC_W = 4;
	localparam int NQ     = MAG_W - FRAC_W;

	localparam int SUM_W     = CHAN_W + 2;
	localparam int LIT_LIMIT = 128 * 3;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic KIND_WRITE = 1'b0;

	localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(256);
	localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(4096);

	typedef enum logic [2:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_CROP_X,
		REG_CROP_Y,
		REG_CROP_W,
		REG_CROP_H,
		REG_OUT_WIDTH,
		REG_OUT_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]        src_width;
		logic [DIM_W-1:0]        src_height;
		logic signed [POS_W-1:0] crop_x;
		logic signed [POS_W-1:0] crop_y;
		logic [POS_W-1:0]        crop_w;
		logic [POS_W-1:0]        crop_h;
		logic [DIM_W-1:0]        out_width;
		logic [DIM_W-1:0]        out_height;
	} cfg_t;

	typedef struct packed {
		logic                  kind;
		logic [SRC_ADDR_W-1:0] src_addr;
		logic [PIX_W-1:0]      pixel;
		logic [COORD_W-1:0]    out_x;
		logic [COORD_W-1:0]    out_y;
	} req_t;

	typedef struct packed {
		logic               lit;
		logic               inside_res;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} res_t;

	typedef struct packed {
		logic               kind;
		logic [ADDR_W-1:0]  addr;
		logic [RGB_W-1:0]   data;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               neg_x;
		logic               neg_y;
	} meta_t;

	typedef struct packed {
		logic               wr;
		logic               in_frame;
		logic [ADDR_W-1:0]  addr;
		logic [RGB_W-1:0]   data;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} cmd_t;

endpackage

`default_nettype wire

### sv/sctb_regs.sv
`default_nettype none

module sctb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sctb_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sctb_pkg::PDATA_W-1:0] pwdata,
	output logic [sctb_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready,
	output sctb_pkg::cfg_t                     cfg
);

	sctb_pkg::cfg_t     cfg_q;
	sctb_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = sctb_pkg::reg_idx_t'(paddr[sctb_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= sctb_pkg::DIM_RESET;
			cfg_q.src_height <= sctb_pkg::DIM_RESET;
			cfg_q.crop_x     <= '0;
			cfg_q.crop_y     <= '0;
			cfg_q.crop_w     <= sctb_pkg::SIZE_RESET;
			cfg_q.crop_h     <= sctb_pkg::SIZE_RESET;
			cfg_q.out_width  <= sctb_pkg::DIM_RESET;
			cfg_q.out_height <= sctb_pkg::DIM_RESET;
		end else if (wr_en) begin
			unique case (idx)
				sctb_pkg::REG_SRC_WIDTH: begin
					cfg_q.src_width <= pwdata[sctb_pkg::DIM_W-1:0];
				end
				sctb_pkg::REG_SRC_HEIGHT: begin
					cfg_q.src_height <= pwdata[sctb_pkg::DIM_W-1:0];
				end
				sctb_pkg::REG_CROP_X: begin
					cfg_q.crop_x <= $signed(pwdata[sctb_pkg::POS_W-1:0]);
				end
				sctb_pkg::REG_CROP_Y: begin
					cfg_q.crop_y <= $signed(pwdata[sctb_pkg::POS_W-1:0]);
				end
				sctb_pkg::REG_CROP_W: begin
					cfg_q.crop_w <= pwdata[sctb_pkg::POS_W-1:0];
				end
				sctb_pkg::REG_CROP_H: begin
					cfg_q.crop_h <= pwdata[sctb_pkg::POS_W-1:0];
				end
				sctb_pkg::REG_OUT_WIDTH: begin
					cfg_q.out_width <= pwdata[sctb_pkg::DIM_W-1:0];
				end
				sctb_pkg::REG_OUT_HEIGHT: begin
					cfg_q.out_height <= pwdata[sctb_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sctb_pkg::REG_SRC_WIDTH:  prdata = sctb_pkg::PDATA_W'(cfg_q.src_width);
			sctb_pkg::REG_SRC_HEIGHT: prdata = sctb_pkg::PDATA_W'(cfg_q.src_height);
			sctb_pkg::REG_CROP_X:     prdata = sctb_pkg::PDATA_W'($unsigned(cfg_q.crop_x));
			sctb_pkg::REG_CROP_Y:     prdata = sctb_pkg::PDATA_W'($unsigned(cfg_q.crop_y));
			sctb_pkg::REG_CROP_W:     prdata = sctb_pkg::PDATA_W'(cfg_q.crop_w);
			sctb_pkg::REG_CROP_H:     prdata = sctb_pkg::PDATA_W'(cfg_q.crop_h);
			sctb_pkg::REG_OUT_WIDTH:  prdata = sctb_pkg::PDATA_W'(cfg_q.out_width);
			sctb_pkg::REG_OUT_HEIGHT: prdata = sctb_pkg::PDATA_W'(cfg_q.out_height);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### sv/sctb_div.sv
`default_nettype none

module sctb_div (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [sctb_pkg::NQ-1:0]    num,
	input  wire logic [sctb_pkg::DIM_W-1:0] divisor,
	output logic [sctb_pkg::NQ-1:0]         quo
);

	localparam int NQ    = sctb_pkg::NQ;
	localparam int DIM_W = sctb_pkg::DIM_W;

	// one quotient bit per stage, msb first
	logic [DIM_W-1:0] rem_s [NQ-1];
	logic [NQ-1:0]    num_s [NQ-1];
	logic [NQ-1:0]    quo_s [NQ];

	for (genvar k = 0; k < NQ; k++) begin : g_stage
		logic [DIM_W-1:0] rem_in;
		logic [NQ-1:0]    num_in;
		logic [NQ-1:0]    quo_in;
		logic [DIM_W:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = {rem_in, num_in[NQ-1]};
		assign take  = trial >= {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_in[NQ-2:0], take};
			end
		end

		if (k < NQ - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? DIM_W'(trial - {1'b0, divisor})
					                 : trial[DIM_W-1:0];
					num_s[k] <= {num_in[NQ-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[NQ-1];

endmodule

`default_nettype wire

### sv/sctb_front.sv
`default_nettype none

module sctb_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sctb_pkg::cfg_t cfg,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire sctb_pkg::req_t req_data,
	input  wire logic           q_full,
	output logic                q_push,
	output sctb_pkg::cmd_t      q_data
);

	localparam int T_W    = sctb_pkg::T_W;
	localparam int MAG_W  = sctb_pkg::MAG_W;
	localparam int NQ     = sctb_pkg::NQ;
	localparam int DIM_W  = sctb_pkg::DIM_W;
	localparam int POS_W  = sctb_pkg::POS_W;
	localparam int LIN_W  = 2 * DIM_W;

	logic adv;

	logic [DIM_W-1:0] div_x;
	logic [DIM_W-1:0] div_y;

	logic                  v_s1;
	sctb_pkg::meta_t       meta_s1;
	logic                  v_s2;
	sctb_pkg::meta_t       meta_s2;
	logic [T_W-1:0]        pa_x_s2;
	logic [T_W-1:0]        pa_y_s2;
	logic signed [T_W-1:0] pb_x_s2;
	logic signed [T_W-1:0] pb_y_s2;
	logic                  v_s3;
	sctb_pkg::meta_t       meta_s3;
	logic signed [T_W-1:0] t_x_s3;
	logic signed [T_W-1:0] t_y_s3;
	logic                  v_s4;
	sctb_pkg::meta_t       meta_s4;
	logic [NQ-1:0]         n_x_s4;
	logic [NQ-1:0]         n_y_s4;

	logic            dly_v_s    [NQ];
	sctb_pkg::meta_t dly_meta_s [NQ];

	logic           cmd_v_q;
	sctb_pkg::cmd_t cmd_q;

	logic [MAG_W-1:0] mag_x;
	logic [MAG_W-1:0] mag_y;
	logic [NQ-1:0]    q_x;
	logic [NQ-1:0]    q_y;
	sctb_pkg::meta_t  fin;
	logic             in_x;
	logic             in_y;
	logic [LIN_W-1:0] lin;

	assign adv       = !cmd_v_q || !q_full;
	assign req_ready = adv;
	assign q_push    = cmd_v_q && !q_full;
	assign q_data    = cmd_q;

	// a zero divisor counts as one
	assign div_x = (cfg.out_width == '0) ? DIM_W'(1) : cfg.out_width;
	assign div_y = (cfg.out_height == '0) ? DIM_W'(1) : cfg.out_height;

	assign mag_x = t_x_s3[T_W-1] ? MAG_W'(-t_x_s3) : MAG_W'(t_x_s3);
	assign mag_y = t_y_s3[T_W-1] ? MAG_W'(-t_y_s3) : MAG_W'(t_y_s3);

	sctb_div u_div_x (
		.clk     (clk),
		.en      (adv),
		.num     (n_x_s4),
		.divisor (div_x),
		.quo     (q_x)
	);

	sctb_div u_div_y (
		.clk     (clk),
		.en      (adv),
		.num     (n_y_s4),
		.divisor (div_y),
		.quo     (q_y)
	);

	// truncation toward zero: a small negative value maps to zero and stays inside
	assign fin  = dly_meta_s[NQ-1];
	assign in_x = (!fin.neg_x || q_x == '0) && (q_x < NQ'(cfg.src_width));
	assign in_y = (!fin.neg_y || q_y == '0) && (q_y < NQ'(cfg.src_height));
	assign lin  = LIN_W'(cfg.src_width) * LIN_W'(q_y[DIM_W-1:0])
	            + LIN_W'(q_x[DIM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			cmd_v_q <= 1'b0;
			for (int k = 0; k < NQ; k++) begin
				dly_v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1       <= req_valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			dly_v_s[0] <= v_s4;
			for (int k = 1; k < NQ; k++) begin
				dly_v_s[k] <= dly_v_s[k-1];
			end
			cmd_v_q <= dly_v_s[NQ-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.kind  <= req_data.kind;
			meta_s1.addr  <= req_data.src_addr[sctb_pkg::ADDR_W-1:0];
			meta_s1.data  <= req_data.pixel[sctb_pkg::RGB_W-1:0];
			meta_s1.col   <= req_data.out_x;
			meta_s1.row   <= req_data.out_y;
			meta_s1.neg_x <= 1'b0;
			meta_s1.neg_y <= 1'b0;

			meta_s2 <= meta_s1;
			pa_x_s2 <= T_W'(meta_s1.col) * T_W'(cfg.crop_w);
			pa_y_s2 <= T_W'(meta_s1.row) * T_W'(cfg.crop_h);
			pb_x_s2 <= $signed({{(T_W-POS_W){cfg.crop_x[POS_W-1]}}, cfg.crop_x})
			         * $signed(T_W'(div_x));
			pb_y_s2 <= $signed({{(T_W-POS_W){cfg.crop_y[POS_W-1]}}, cfg.crop_y})
			         * $signed(T_W'(div_y));

			meta_s3 <= meta_s2;
			t_x_s3  <= $signed(pa_x_s2) + pb_x_s2;
			t_y_s3  <= $signed(pa_y_s2) + pb_y_s2;

			meta_s4.kind  <= meta_s3.kind;
			meta_s4.addr  <= meta_s3.addr;
			meta_s4.data  <= meta_s3.data;
			meta_s4.col   <= meta_s3.col;
			meta_s4.row   <= meta_s3.row;
			meta_s4.neg_x <= t_x_s3[T_W-1];
			meta_s4.neg_y <= t_y_s3[T_W-1];
			n_x_s4        <= mag_x[MAG_W-1:sctb_pkg::FRAC_W];
			n_y_s4        <= mag_y[MAG_W-1:sctb_pkg::FRAC_W];

			dly_meta_s[0] <= meta_s4;
			for (int k = 1; k < NQ; k++) begin
				dly_meta_s[k] <= dly_meta_s[k-1];
			end

			cmd_q.wr       <= fin.kind == sctb_pkg::KIND_WRITE;
			cmd_q.in_frame <= in_x && in_y;
			cmd_q.addr     <= (fin.kind == sctb_pkg::KIND_WRITE) ? fin.addr
			                                                     : lin[sctb_pkg::ADDR_W-1:0];
			cmd_q.data     <= fin.data;
			cmd_q.col      <= fin.col;
			cmd_q.row      <= fin.row;
		end
	end

endmodule

`default_nettype wire

### sv/sctb_queue.sv
`default_nettype none

module sctb_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sctb_pkg::cmd_t din,
	input  wire logic           pop,
	output sctb_pkg::cmd_t      dout,
	output logic                full,
	output logic                empty
);

	localparam int PW = sctb_pkg::Q_PTR_W;

	sctb_pkg::cmd_t slot_q [sctb_pkg::Q_DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [PW:0]    cnt_q;

	assign full  = cnt_q == (PW+1)'(sctb_pkg::Q_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

endmodule

`default_nettype wire

### sv/sctb_back.sv
`default_nettype none

module sctb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire sctb_pkg::cmd_t q_data,
	output logic                q_pop,
	output logic                res_valid,
	input  wire logic           res_ready,
	output sctb_pkg::res_t      res_data
);

	localparam int CHAN_W = sctb_pkg::CHAN_W;
	localparam int SUM_W  = sctb_pkg::SUM_W;

	logic [sctb_pkg::RGB_W-1:0] frame_mem [sctb_pkg::FRAME_DEPTH];

	logic                         m_v_s1;
	logic                         inside_s1;
	logic [sctb_pkg::COORD_W-1:0] col_s1;
	logic [sctb_pkg::COORD_W-1:0] row_s1;
	logic [sctb_pkg::RGB_W-1:0]   rd_s1;

	logic           res_v_q;
	sctb_pkg::res_t res_q;

	logic             m_adv;
	logic             m_free;
	logic [SUM_W-1:0] sum;

	assign m_adv  = !res_v_q || res_ready;
	assign m_free = !m_v_s1 || m_adv;
	assign q_pop  = !q_empty && m_free;

	assign res_valid = res_v_q;
	assign res_data  = res_q;

	assign sum = SUM_W'(rd_s1[3*CHAN_W-1:2*CHAN_W]) + SUM_W'(rd_s1[2*CHAN_W-1:CHAN_W])
	           + SUM_W'(rd_s1[CHAN_W-1:0]);

	// single port: one write or one read per cycle, in request order
	always_ff @(posedge clk) begin
		if (q_pop && q_data.wr) begin
			frame_mem[q_data.addr] <= q_data.data;
		end
		if (q_pop && !q_data.wr && q_data.in_frame) begin
			rd_s1 <= frame_mem[q_data.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_s1  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (m_free) begin
				m_v_s1 <= q_pop && !q_data.wr;
			end
			if (m_adv) begin
				res_v_q <= m_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			inside_s1 <= q_data.in_frame;
			col_s1    <= q_data.col;
			row_s1    <= q_data.row;
		end
		if (m_adv && m_v_s1) begin
			res_q.lit        <= inside_s1 && (sum > SUM_W'(sctb_pkg::LIT_LIMIT));
			res_q.inside_res <= inside_s1;
			res_q.col        <= col_s1;
			res_q.row        <= row_s1;
		end
	end

endmodule

`default_nettype wire

### sv/scaled_crop_threshold_binarizer_core.sv
// channel   direction  handshake             payload
// cfg       in         psel/penable/pready   paddr, pwdata, prdata (apb style)
// req       in         req_valid/req_ready   req_data (sctb_pkg::req_t)
// res       out        res_valid/res_ready   res_data (sctb_pkg::res_t)
//
// one request per cycle sustained unless a full queue stalls the front; a query result
// passes the mapping pipeline, most of whose depth is the 18-stage radix-2 divider
// writes give no result and reach the frame memory in order with queries
// arst_n clears control state only; the frame memory has no clearing pass
// a stalled result only backs up the 4-entry queue, then req_ready drops
`default_nettype none

module scaled_crop_threshold_binarizer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sctb_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sctb_pkg::PDATA_W-1:0] pwdata,
	output logic [sctb_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire sctb_pkg::req_t                req_data,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output sctb_pkg::res_t                     res_data
);

	sctb_pkg::cfg_t cfg;
	sctb_pkg::cmd_t push_data;
	sctb_pkg::cmd_t head_data;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;

	sctb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sctb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	sctb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_data),
		.pop    (q_pop),
		.dout   (head_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	sctb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (head_data),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

### verif/scaled_crop_threshold_binarizer_core_tb.sv
`timescale 1ns / 1ps

module scaled_crop_threshold_binarizer_core_tb;
	import sctb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;
	localparam logic KIND_QUERY = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res_data;

	cfg_t model_cfg;
	logic [RGB_W-1:0] frame_mem [FRAME_DEPTH];
	bit frame_written [FRAME_DEPTH];
	res_t pixel_results_q [$];
	int mismatches = 0;
	int cycles = 0;
	bit send_gaps = 1'b1;
	bit recv_stalls = 1'b1;
	int hold_left = 0;
	int stall_left = 0;

	scaled_crop_threshold_binarizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 16);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %0d: %s expected %h got %h", mismatches, what, want, got);
	endfunction

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pixel_results_q.size() == 0) begin
				note_mismatch("result with nothing outstanding", '0, 32'(res_data));
			end else begin
				want = pixel_results_q.pop_front();
				if (res_data.lit !== want.lit)
					note_mismatch($sformatf("lit at (%0d,%0d)", want.col, want.row),
						32'(want.lit), 32'(res_data.lit));
				if (res_data.inside_res !== want.inside_res)
					note_mismatch($sformatf("inside_res at (%0d,%0d)", want.col, want.row),
						32'(want.inside_res), 32'(res_data.inside_res));
				if (res_data.col !== want.col)
					note_mismatch("col", 32'(want.col), 32'(res_data.col));
				if (res_data.row !== want.row)
					note_mismatch("row", 32'(want.row), 32'(res_data.row));
			end
		end
	end

	function automatic longint scale_axis(longint o, longint size, longint pos, longint osize);
		longint div;
		div = (osize == 0) ? 1 : osize;
		return (o * size + pos * div) / (16 * div);
	endfunction

	function automatic bit map_to_source(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
			output logic [ADDR_W-1:0] addr);
		longint sx, sy, w, h;
		bit hit;
		w = longint'(model_cfg.src_width);
		h = longint'(model_cfg.src_height);
		sx = scale_axis(longint'(ox), longint'(model_cfg.crop_w),
			longint'($signed(model_cfg.crop_x)), longint'(model_cfg.out_width));
		sy = scale_axis(longint'(oy), longint'(model_cfg.crop_h),
			longint'($signed(model_cfg.crop_y)), longint'(model_cfg.out_height));
		hit = sx >= 0 && sy >= 0 && sx < w && sy < h;
		addr = hit ? ADDR_W'(sx + w * sy) : '0;
		return hit;
	endfunction

	function automatic void predict_pixel(req_t r);
		res_t want;
		logic [ADDR_W-1:0] addr;
		logic [RGB_W-1:0] rgb;
		if (r.kind == KIND_WRITE) begin
			frame_mem[r.src_addr] = r.pixel[RGB_W-1:0];
			frame_written[r.src_addr] = 1'b1;
		end else begin
			want.col = r.out_x;
			want.row = r.out_y;
			want.inside_res = map_to_source(r.out_x, r.out_y, addr);
			want.lit = 1'b0;
			if (want.inside_res) begin
				rgb = frame_mem[addr];
				want.lit = (int'(rgb[23:16]) + int'(rgb[15:8]) + int'(rgb[7:0])) > LIT_LIMIT;
			end
			pixel_results_q.push_back(want);
		end
	endfunction

	// called and returns at a falling edge
	task automatic send_item(req_t r);
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_pixel(r);
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	function automatic req_t noise_req();
		req_t r;
		r.kind = 1'($urandom_range(0, 1));
		r.src_addr = SRC_ADDR_W'($urandom());
		r.pixel = $urandom();
		r.out_x = COORD_W'($urandom());
		r.out_y = COORD_W'($urandom());
		return r;
	endfunction

	task automatic send_write(logic [SRC_ADDR_W-1:0] addr, logic [PIX_W-1:0] pix);
		req_t r;
		r = noise_req();
		r.kind = KIND_WRITE;
		r.src_addr = addr;
		r.pixel = pix;
		send_item(r);
	endtask

	// never lets a query land on a frame entry that was not written
	task automatic send_query(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
		req_t r;
		logic [ADDR_W-1:0] addr;
		if (map_to_source(ox, oy, addr) && !frame_written[addr])
			send_write(addr, $urandom());
		r = noise_req();
		r.kind = KIND_QUERY;
		r.out_x = ox;
		r.out_y = oy;
		send_item(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pixel_results_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] cfg_value(reg_idx_t idx);
		case (idx)
			REG_SRC_WIDTH: return 32'(model_cfg.src_width);
			REG_SRC_HEIGHT: return 32'(model_cfg.src_height);
			REG_CROP_X: return 32'(unsigned'(model_cfg.crop_x));
			REG_CROP_Y: return 32'(unsigned'(model_cfg.crop_y));
			REG_CROP_W: return 32'(model_cfg.crop_w);
			REG_CROP_H: return 32'(model_cfg.crop_h);
			REG_OUT_WIDTH: return 32'(model_cfg.out_width);
			default: return 32'(model_cfg.out_height);
		endcase
	endfunction

	function automatic logic [31:0] reg_mask(reg_idx_t idx);
		case (idx)
			REG_CROP_X, REG_CROP_Y, REG_CROP_W, REG_CROP_H: return (32'd1 << POS_W) - 1;
			default: return (32'd1 << DIM_W) - 1;
		endcase
	endfunction

	task automatic check_reg(reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'(4 * idx);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & reg_mask(idx)) !== cfg_value(idx))
			note_mismatch($sformatf("register %s readback", idx.name()), cfg_value(idx),
				prdata & reg_mask(idx));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * idx);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SRC_WIDTH: model_cfg.src_width = value[DIM_W-1:0];
			REG_SRC_HEIGHT: model_cfg.src_height = value[DIM_W-1:0];
			REG_CROP_X: model_cfg.crop_x = value[POS_W-1:0];
			REG_CROP_Y: model_cfg.crop_y = value[POS_W-1:0];
			REG_CROP_W: model_cfg.crop_w = value[POS_W-1:0];
			REG_CROP_H: model_cfg.crop_h = value[POS_W-1:0];
			REG_OUT_WIDTH: model_cfg.out_width = value[DIM_W-1:0];
			default: model_cfg.out_height = value[DIM_W-1:0];
		endcase
		@(negedge clk);
		check_reg(idx);
	endtask

	task automatic apply_cfg(int sw, int sh, int cx, int cy, int cw, int ch, int ow, int oh);
		wait_drained();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_CROP_X, cx);
		write_reg(REG_CROP_Y, cy);
		write_reg(REG_CROP_W, cw);
		write_reg(REG_CROP_H, ch);
		write_reg(REG_OUT_WIDTH, ow);
		write_reg(REG_OUT_HEIGHT, oh);
	endtask

	task automatic run_mixed_traffic(int n);
		logic [COORD_W-1:0] ox, oy;
		logic [ADDR_W-1:0] addr;
		repeat (n) begin
			ox = COORD_W'($urandom());
			oy = COORD_W'($urandom());
			if ($urandom_range(0, 99) < 35) begin
				if ($urandom_range(0, 1) && map_to_source(ox, oy, addr)) begin
					send_write(addr, $urandom());
					if ($urandom_range(0, 1))
						send_query(ox, oy);
				end else begin
					send_write(SRC_ADDR_W'($urandom()), $urandom());
				end
			end else begin
				send_query(ox, oy);
			end
		end
	endtask

	task automatic test_reset_values();
		for (int i = 0; i <= int'(REG_OUT_HEIGHT); i++)
			check_reg(reg_idx_t'(i));
	endtask

	task automatic test_threshold_edges();
		send_write(16'd0, 32'hFF00_0000);
		send_query(8'd0, 8'd0);
		send_write(16'd1, 32'h0080_8080);
		send_query(8'd1, 8'd0);
		send_write(16'd2, 32'h0080_8081);
		send_query(8'd2, 8'd0);
		send_write(16'd65535, 32'hFFFF_FFFF);
		send_query(8'd255, 8'd255);
		send_write(16'd255, 32'h00FF_FFFF);
		send_query(8'd255, 8'd0);
		send_write(16'd65280, 32'h7F00_0000);
		send_query(8'd0, 8'd255);
		send_write(16'd0, 32'h00FF_FF00);
		send_query(8'd0, 8'd0);
	endtask

	task automatic test_mapping_corners();
		// negative fraction truncates to zero
		apply_cfg(256, 256, -8, -15, 4096, 4096, 256, 256);
		send_query(8'd0, 8'd0);
		// crop fully left of the frame
		apply_cfg(256, 256, -4096, 0, 4096, 4096, 256, 256);
		send_query(8'd255, 8'd0);
		// coordinates past the output size
		apply_cfg(256, 256, 0, 0, 4096, 4096, 16, 16);
		send_query(8'd20, 8'd3);
		send_query(8'd15, 8'd15);
		// zero divisor
		apply_cfg(256, 256, 0, 0, 16, 16, 0, 0);
		send_query(8'd7, 8'd9);
		// empty crop collapses to its origin
		apply_cfg(256, 256, 80, 4095, 0, 0, 256, 256);
		send_query(8'd3, 8'd200);
		// stride past the frame wraps the address
		apply_cfg(511, 511, 0, 0, 4096, 4096, 256, 256);
		send_query(8'd200, 8'd200);
		// empty frame
		apply_cfg(0, 0, 0, 0, 4096, 4096, 256, 256);
		send_query(8'd0, 8'd0);
	endtask

	task automatic test_random_settings();
		int sw, sh;
		apply_cfg(256, 256, 0, 0, 4096, 4096, 256, 256);
		run_mixed_traffic(110);
		apply_cfg(1, 1, -4096, -4096, 0, 0, 1, 1);
		run_mixed_traffic(40);
		apply_cfg(256, 256, 4095, 4095, 4096, 4096, 256, 256);
		run_mixed_traffic(50);
		apply_cfg(100, 60, -40, 24, 2000, 1500, 37, 200);
		run_mixed_traffic(110);
		apply_cfg(511, 511, 4095, -4096, 8191, 8191, 0, 511);
		run_mixed_traffic(50);
		apply_cfg(2, 3, 0, 0, 32, 48, 2, 3);
		run_mixed_traffic(80);
		repeat (4) begin
			sw = $urandom_range(1, 256);
			sh = $urandom_range(1, 256);
			apply_cfg(sw, sh, int'($urandom_range(0, sw * 16)) - int'($urandom_range(0, 256)),
				int'($urandom_range(0, sh * 16)) - int'($urandom_range(0, 256)),
				$urandom_range(0, 4096), $urandom_range(0, 4096),
				$urandom_range(1, 256), $urandom_range(1, 256));
			run_mixed_traffic(110);
		end
	endtask

	task automatic test_backpressure();
		apply_cfg(256, 256, 0, 0, 4096, 4096, 256, 256);
		send_gaps = 1'b0;
		hold_left = 300;
		repeat (80) send_query(COORD_W'($urandom()), COORD_W'($urandom()));
		send_gaps = 1'b1;
	endtask

	task automatic test_pause_and_resume();
		run_mixed_traffic(30);
		wait_drained();
		run_mixed_traffic(30);
	endtask

	task automatic test_full_rate();
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		run_mixed_traffic(150);
	endtask

	initial begin
		model_cfg.src_width = DIM_RESET;
		model_cfg.src_height = DIM_RESET;
		model_cfg.crop_x = '0;
		model_cfg.crop_y = '0;
		model_cfg.crop_w = SIZE_RESET;
		model_cfg.crop_h = SIZE_RESET;
		model_cfg.out_width = DIM_RESET;
		model_cfg.out_height = DIM_RESET;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_values();
		test_threshold_edges();
		test_mapping_corners();
		test_random_settings();
		test_backpressure();
		test_pause_and_resume();
		test_full_rate();
		wait_drained();
		if (mismatches == 0 && pixel_results_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
